### hdl/base32_stream_encoder_macros.svh
// Assertion macros shared by the base32 stream encoder modules.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define B32SE_ASSERT_NOW(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define B32SE_ASSERT_NEXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

### hdl/b32se_pkg.sv
// Types, constants and helper functions of the base32 stream encoder.
package b32se_pkg;

	localparam int BYTE_W      = 8;
	localparam int CHAR_W      = 7;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHAR_A   = 7'h41;  // 'A'
	localparam logic [CHAR_W-1:0] CHAR_2   = 7'h32;  // '2'
	localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3D;  // '='

	// One byte's worth of work: up to three data characters, then padding.
	typedef struct packed {
		logic [2:0][CHAR_W-1:0] chars;
		logic [1:0]             ndata;
		logic [2:0]             npad;
		logic                   fin;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Map a 5-bit code onto A-Z, 2-7.
	function automatic logic [CHAR_W-1:0] b32_char(input logic [4:0] idx);
		if (idx < 5'd26) begin
			return CHAR_A + CHAR_W'(idx);
		end else begin
			return CHAR_2 + CHAR_W'(idx - 5'd26);
		end
	endfunction

	// Padding that closes the 8-character group, by position of the final byte.
	function automatic logic [2:0] pad_count(input logic [2:0] pos);
		logic [2:0] n;
		case (pos)
			3'd0:    n = 3'd6;
			3'd1:    n = 3'd4;
			3'd2:    n = 3'd3;
			3'd3:    n = 3'd1;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

### hdl/b32se_if.sv
// Stream interfaces of the base32 encoder: byte requests in, characters out.
interface b32se_byte_if;
	logic                        valid;
	logic                        ready;
	logic [b32se_pkg::BYTE_W-1:0] data_byte;
	logic                        final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b32se_char_if;
	logic                        valid;
	logic                        ready;
	logic [b32se_pkg::CHAR_W-1:0] out_char;
	logic                        last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

### hdl/base32_stream_encoder.sv
// Top level of the streaming base32 encoder.
//
//  channel   | dir | payload                                | role
//  ----------+-----+----------------------------------------+------------------------------
//  byte_in   | in  | data_byte[7:0], final_byte             | one message byte per request
//  char_out  | out | out_char[6:0], last_char               | one base32 or '=' character
//
// A byte request is taken in any cycle the job queue has room, so bytes may come
// back to back. The back end sends one character per cycle from its output
// register while char_out is ready; that single character port sets throughput,
// and a final byte that closes a group also sends its padding through it. The
// first character of a byte passes the job queue and then the output register.
// arst_n clears the bit accumulator, group position, queue and output valid.
// A stall on char_out holds the output register; the queue absorbs QUEUE_DEPTH
// jobs before byte_in.ready drops.
module base32_stream_encoder #(
	parameter int QUEUE_DEPTH = b32se_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	b32se_byte_if.sink   byte_in,
	b32se_char_if.source char_out
);

	logic              push;
	logic              pop;
	b32se_pkg::job_t   push_job;
	b32se_pkg::job_t   head;
	b32se_pkg::qstat_t qstat;

	// Front: slice each byte into 5-bit codes, decide flush and padding.
	b32se_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.qstat    (qstat),
		.push     (push),
		.push_job (push_job)
	);

	// Queue: decouple byte intake from character output.
	b32se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// Back: advance through the head job, one character per cycle while char_out is ready.
	b32se_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.qstat    (qstat),
		.pop      (pop),
		.char_out (char_out)
	);

endmodule

### hdl/b32se_queue.sv
// Short job queue between the encoder front and back.
`include "base32_stream_encoder_macros.svh"

module b32se_queue #(
	parameter int DEPTH = b32se_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  b32se_pkg::job_t   push_job,
	input  logic              pop,
	output b32se_pkg::job_t   head,
	output b32se_pkg::qstat_t qstat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	b32se_pkg::job_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end else begin
			return p + PTR_W'(1);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign qstat.empty = (cnt_q == '0);

	`B32SE_ASSERT_NOW(a_no_overflow, push, !qstat.full, "queue written while full")
	`B32SE_ASSERT_NOW(a_no_underflow, pop, !qstat.empty, "queue read while empty")

endmodule

### hdl/b32se_front.sv
// Encoder front: take byte requests, slice the bit accumulator, queue jobs.
`include "base32_stream_encoder_macros.svh"

module b32se_front (
	input  logic              clk,
	input  logic              arst_n,
	b32se_byte_if.sink        byte_in,
	input  b32se_pkg::qstat_t qstat,
	output logic              push,
	output b32se_pkg::job_t   push_job
);

	logic [3:0]  acc_q;   // unemitted low bits, at most four
	logic [2:0]  pend_q;  // how many of acc_q are live, 0..4
	logic [2:0]  pos_q;   // byte position in the 5-byte group

	logic [11:0] acc_w;
	logic [3:0]  pend_w;
	logic        two_w;
	logic [2:0]  sh0_w;
	logic [1:0]  sh1_w;
	logic [2:0]  rem_w;
	logic [4:0]  idx0_w;
	logic [4:0]  idx1_w;
	logic [4:0]  flush_w;
	logic        has_flush_w;
	logic        clear_w;

	assign byte_in.ready = !qstat.full;
	assign push          = byte_in.valid && byte_in.ready;
	assign clear_w       = (acc_q == 4'd0) && (pend_q == 3'd0) && (pos_q == 3'd0);

	always_comb begin
		acc_w       = {acc_q, byte_in.data_byte};
		pend_w      = {1'b0, pend_q} + 4'd8;
		two_w       = (pend_w >= 4'd10);
		sh0_w       = 3'(pend_w - 4'd5);
		sh1_w       = 2'(pend_w - 4'd10);
		rem_w       = two_w ? {1'b0, sh1_w} : sh0_w;
		idx0_w      = 5'(acc_w >> sh0_w);
		idx1_w      = 5'(acc_w >> sh1_w);
		// leftover bits, left-aligned and zero-filled
		flush_w     = acc_w[4:0] << (3'd5 - rem_w);
		has_flush_w = byte_in.final_byte && (rem_w != 3'd0);

		push_job.chars[0] = b32se_pkg::b32_char(idx0_w);
		push_job.chars[1] = b32se_pkg::b32_char(two_w ? idx1_w : flush_w);
		push_job.chars[2] = b32se_pkg::b32_char(flush_w);
		push_job.ndata    = 2'(2'd1 + {1'b0, two_w} + {1'b0, has_flush_w});
		push_job.npad     = byte_in.final_byte ? b32se_pkg::pad_count(pos_q) : 3'd0;
		push_job.fin      = byte_in.final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
			pos_q  <= '0;
		end else if (push) begin
			if (byte_in.final_byte) begin
				acc_q  <= '0;
				pend_q <= '0;
				pos_q  <= '0;
			end else begin
				acc_q  <= acc_w[3:0];
				pend_q <= rem_w;
				pos_q  <= (pos_q >= 3'd4) ? 3'd0 : pos_q + 3'd1;
			end
		end
	end

	`B32SE_ASSERT_NEXT(a_final_clears, push && byte_in.final_byte, clear_w, "final byte left state")
	`B32SE_ASSERT_NOW(a_pend_range, 1'b1, pend_q <= 3'd4, "pending bit count out of range")

endmodule

### hdl/b32se_back.sv
// Encoder back: walk the head job one character per cycle into the output register, unless stalled.
`include "base32_stream_encoder_macros.svh"

module b32se_back (
	input  logic              clk,
	input  logic              arst_n,
	input  b32se_pkg::job_t   head,
	input  b32se_pkg::qstat_t qstat,
	output logic              pop,
	b32se_char_if.source      char_out
);

	logic [2:0]                   idx_q;
	logic                         out_valid_q;
	logic [b32se_pkg::CHAR_W-1:0] out_char_q;
	logic                         out_last_q;

	logic [3:0]                   total_w;
	logic                         last_w;
	logic                         load_w;
	logic [b32se_pkg::CHAR_W-1:0] char_w;

	always_comb begin
		total_w = 4'({2'b00, head.ndata} + {1'b0, head.npad});
		last_w  = (({1'b0, idx_q} + 4'd1) == total_w);
		load_w  = !out_valid_q || char_out.ready;
		if (idx_q < {1'b0, head.ndata}) begin
			char_w = head.chars[idx_q[1:0]];
		end else begin
			char_w = b32se_pkg::PAD_CHAR;
		end
	end

	assign pop = load_w && !qstat.empty && last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load_w) begin
			out_valid_q <= !qstat.empty;
			if (!qstat.empty) begin
				idx_q <= last_w ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_w && !qstat.empty) begin
			out_char_q <= char_w;
			out_last_q <= head.fin && last_w;
		end
	end

	assign char_out.valid     = out_valid_q;
	assign char_out.out_char  = out_char_q;
	assign char_out.last_char = out_last_q;

	`B32SE_ASSERT_NOW(a_idx_in_job, !qstat.empty, {1'b0, idx_q} < total_w, "index past end of job")

endmodule

### dv/base32_stream_encoder_tb.sv
// Self-checking testbench for the streaming base32 encoder.
module base32_stream_encoder_tb;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 8;

	typedef enum int {RX_OPEN, RX_PATTERN, RX_HEAVY, RX_HOLD} rx_mode_t;

	// Tracks encoder state and holds the characters still owed by the block.
	class char_scoreboard;
		logic [11:0] acc;
		logic [2:0]  pend;
		logic [2:0]  pos;
		logic [7:0]  encoded_chars[$];  // {last_char, out_char}
		int          errors;
		int          checked;
		int          bytes_seen;
		int          msgs_seen;
		bit [4:0]    final_pos_seen;

		function new();
			acc  = '0;
			pend = '0;
			pos  = '0;
		endfunction

		function logic [b32se_pkg::CHAR_W-1:0] code_of(logic [4:0] idx);
			if (idx < 5'd26) begin
				return b32se_pkg::CHAR_A + {2'b00, idx};
			end else begin
				return b32se_pkg::CHAR_2 + {2'b00, idx - 5'd26};
			end
		endfunction

		function void note_byte(logic [7:0] b, logic fin);
			logic [11:0] a;
			int          p;
			int          npad;
			int          first;
			logic [7:0]  tail;
			a = {acc[3:0], b};
			p = int'(pend) + 8;
			first = encoded_chars.size();
			bytes_seen++;
			while (p >= 5) begin
				encoded_chars.push_back({1'b0, code_of(5'(a >> (p - 5)))});
				p -= 5;
			end
			if (fin) begin
				// flush leftover bits, zero-filled on the right
				if (p > 0) begin
					encoded_chars.push_back({1'b0, code_of(5'(a << (5 - p)))});
				end
				case (pos)
					3'd0:    npad = 6;
					3'd1:    npad = 4;
					3'd2:    npad = 3;
					3'd3:    npad = 1;
					default: npad = 0;
				endcase
				repeat (npad) encoded_chars.push_back({1'b0, b32se_pkg::PAD_CHAR});
				if (encoded_chars.size() > first) begin
					tail = encoded_chars.pop_back();
					tail[7] = 1'b1;
					encoded_chars.push_back(tail);
				end
				if (pos <= 3'd4) final_pos_seen[pos] = 1'b1;
				msgs_seen++;
				acc  = '0;
				pend = '0;
				pos  = '0;
			end else begin
				acc  = a;
				pend = 3'(p);
				pos  = (pos >= 3'd4) ? 3'd0 : pos + 3'd1;
			end
		endfunction

		function void check_char(logic [b32se_pkg::CHAR_W-1:0] c, logic l);
			logic [7:0] e;
			if (encoded_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none, actual char %0d last %0b",
					$time, c, l);
				errors++;
				return;
			end
			e = encoded_chars.pop_front();
			checked++;
			if (e[6:0] !== c) begin
				$display("%0t: out_char mismatch: expected %0d, actual %0d", $time, e[6:0], c);
				errors++;
			end
			if (e[7] !== l) begin
				$display("%0t: last_char mismatch: expected %0b, actual %0b", $time, e[7], l);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	b32se_byte_if byte_ch ();
	b32se_char_if char_ch ();

	base32_stream_encoder DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_ch),
		.char_out (char_ch)
	);

	char_scoreboard sb = new();
	rx_mode_t       rx_mode = RX_PATTERN;
	bit             gaps_on = 1'b1;
	int             burst_left = 1;
	int             idle_cycles = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Check every accepted character against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && char_ch.valid && char_ch.ready) begin
			sb.check_char(char_ch.out_char, char_ch.last_char);
		end
	end

	// End the run if nothing moves on either channel for too long.
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired with %0d characters outstanding",
				$time, sb.encoded_chars.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: always ready, stall on a rotating pattern, at random, or hold off entirely.
	initial begin
		logic [7:0] pattern;
		int         cnt;
		int         hold_cnt;
		pattern  = 8'b1011_0110;
		cnt      = 0;
		hold_cnt = 0;
		char_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cnt++;
			case (rx_mode)
				RX_OPEN: begin
					char_ch.ready <= 1'b1;
				end
				RX_PATTERN: begin
					if (cnt % 32 == 0) pattern = 8'($urandom) | 8'h01;
					pattern = {pattern[6:0], pattern[7]};
					char_ch.ready <= pattern[0];
				end
				RX_HEAVY: begin
					char_ch.ready <= ($urandom_range(0, 99) >= 75);
				end
				RX_HOLD: begin
					char_ch.ready <= 1'b0;
					hold_cnt++;
					if (hold_cnt >= HOLD_CYCLES) begin
						hold_cnt = 0;
						rx_mode = RX_PATTERN;
					end
				end
			endcase
		end
	end

	// Offer a message one byte per request; mark the last one final.
	task automatic send_msg(input logic [7:0] msg[$]);
		for (int i = 0; i < msg.size(); i++) begin
			byte_ch.valid      <= 1'b1;
			byte_ch.data_byte  <= msg[i];
			byte_ch.final_byte <= (i == msg.size() - 1);
			@(posedge clk);
			while (!byte_ch.ready) @(posedge clk);
			sb.note_byte(msg[i], i == msg.size() - 1);
			burst_left--;
			if (gaps_on && burst_left <= 0) begin
				byte_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end
		end
	endtask

	task automatic send_random_msg(input int max_len);
		logic [7:0] msg[$];
		int         len;
		int         pick;
		len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 7) : $urandom_range(8, max_len);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) msg.push_back(8'h00);
			else if (pick == 1) msg.push_back(8'hFF);
			else msg.push_back(8'($urandom));
		end
		send_msg(msg);
	endtask

	// Stop offering and hold until every owed character has arrived.
	task automatic drain();
		byte_ch.valid <= 1'b0;
		while (sb.encoded_chars.size() != 0) @(posedge clk);
	endtask

	initial begin
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.final_byte = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: final byte at each group position, extreme bytes, a full group.
		send_msg('{8'h00});
		send_msg('{8'hFF});
		send_msg('{8'hFF, 8'h00});
		send_msg('{8'hA5, 8'h5A, 8'hFF});
		send_msg('{8'h00, 8'hFF, 8'h80, 8'h01});
		send_msg('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_msg('{8'h66, 8'h6F, 8'h6F, 8'h62, 8'h61, 8'h72});

		// Random messages, bursty sender, patterned receiver.
		while (sb.bytes_seen < 80) send_random_msg(16);

		// Hold the receiver off while the sender keeps pushing.
		gaps_on = 1'b0;
		rx_mode = RX_HOLD;
		repeat (3) send_random_msg(12);

		// Pause the sender until the block has delivered everything.
		drain();

		// Full rate on both sides.
		rx_mode = RX_OPEN;
		while (sb.bytes_seen < 130) send_random_msg(16);

		// Heavy output stalls with a bursty sender again.
		gaps_on = 1'b1;
		rx_mode = RX_HEAVY;
		while (sb.bytes_seen < 165) send_random_msg(16);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d bytes in %0d messages, %0d characters checked,",
			sb.bytes_seen, sb.msgs_seen, sb.checked);
		$display("final-byte group positions hit %05b, long output hold and a drain pause.",
			sb.final_pos_seen);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/b32se_pkg.sv
hdl/b32se_if.sv
hdl/b32se_queue.sv
hdl/b32se_front.sv
hdl/b32se_back.sv
hdl/base32_stream_encoder.sv
dv/base32_stream_encoder_tb.sv
